[rtl/core/oms_pkg.sv]
// Shared types and constants for the oversampled moving average scaler.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package oms_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned VOLT_BITS   = 16;
  localparam int unsigned COEF_BITS   = 32;

  localparam logic [COEF_BITS-1:0] COEF_RESET = 32'd65536;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic                   op;
    logic [SAMPLE_BITS-1:0] sample;
  } in_req_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] filtered_average;
    logic [VOLT_BITS-1:0]   voltage;
  } out_res_t;

  typedef struct packed {
    logic                   clr;
    logic [SAMPLE_BITS-1:0] avg;
  } blk_t;

endpackage

`default_nettype wire

[rtl/core/oversampled_moving_average_scaler_top.sv]
// Top level: boxcar decimator, 32-deep moving average and Q16.16 scaler.
// Instantiates oms_decim, oms_ring and oms_scale; depends on oms_pkg.
//
// Usage:
//   in_*  : valid/ready requests carrying op (sample or clear) and a 12-bit sample.
//   out_* : valid/ready results carrying filtered_average and voltage.
//   cfg_* : cfg_wr_en writes cfg_wr_data into the scale coefficient the same
//           edge; write only while the block is idle.
//   Every GROUP_SIZE-th sample request yields one result; clear requests and
//   other samples yield none. A clear request empties the accumulator, the ring
//   and the running sum, in order with the requests ahead of it.
//   Throughput: one request per cycle while the receiver takes results. The
//   result of the request that completes a group passes through the six
//   pipeline registers (group sum, block average, ring read, ring sum, window
//   average, result).
//   Reset (rst_n low, synchronous) empties the pipeline and the ring and loads
//   the coefficient with 1.0; the block is ready the cycle after release.
//   When the receiver stalls, results hold in the output register and the
//   stages behind it keep filling until each holds a request.
`timescale 1ns / 1ps
`default_nettype none

module oversampled_moving_average_scaler_top #(
  parameter int GROUP_SIZE     = 16,
  parameter int WINDOW_DEPTH   = 32,
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire oms_pkg::in_req_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output oms_pkg::out_res_t                  out_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [oms_pkg::COEF_BITS-1:0] cfg_wr_data
);

  localparam int RSUM_W = $clog2(WINDOW_DEPTH * ((1 << oms_pkg::SAMPLE_BITS) - 1) + 1);

  logic [oms_pkg::COEF_BITS-1:0] coef_r;
  logic                          dec_valid;
  logic                          dec_ready;
  oms_pkg::blk_t                 dec_data;
  logic                          ring_valid;
  logic                          ring_ready;
  logic [RSUM_W-1:0]             ring_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= oms_pkg::COEF_RESET;
    end else if (cfg_wr_en) begin
      coef_r <= cfg_wr_data;
    end
  end

  oms_decim #(
    .GROUP_SIZE (GROUP_SIZE)
  ) u_decim (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .blk_valid (dec_valid),
    .blk_ready (dec_ready),
    .blk_data  (dec_data)
  );

  oms_ring #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .RSUM_W       (RSUM_W)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .blk_valid (dec_valid),
    .blk_ready (dec_ready),
    .blk_data  (dec_data),
    .sum_valid (ring_valid),
    .sum_ready (ring_ready),
    .sum_data  (ring_sum)
  );

  oms_scale #(
    .WINDOW_DEPTH   (WINDOW_DEPTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .RSUM_W         (RSUM_W)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (ring_valid),
    .sum_ready (ring_ready),
    .sum_data  (ring_sum),
    .coef      (coef_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_reset_empties_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_dec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    dec_valid && !dec_ready |=> dec_valid && $stable(dec_data))
    else $error("block average changed while stalled");

  a_ring_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ring_valid && !ring_ready |=> ring_valid && $stable(ring_sum))
    else $error("ring sum changed while stalled");

  a_scale_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> ring_ready)
    else $error("scaler stalled with an empty output register");

endmodule

`default_nettype wire

[rtl/core/oms_decim.sv]
// Group accumulator and block average divider (two pipeline stages).
// Depends on oms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oms_decim #(
  parameter int GROUP_SIZE = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire oms_pkg::in_req_t in_data,
  output logic                 blk_valid,
  input  wire logic            blk_ready,
  output oms_pkg::blk_t        blk_data
);

  localparam int GSUM_W = $clog2(GROUP_SIZE * ((1 << oms_pkg::SAMPLE_BITS) - 1) + 1);
  localparam int CNT_W  = $clog2(GROUP_SIZE);
  localparam int GK     = GSUM_W + $clog2(GROUP_SIZE);
  localparam int GM_W   = GSUM_W + 1;
  localparam int GP_W   = GSUM_W + GM_W;
  localparam logic [GM_W-1:0] GDIV_M =
    GM_W'(((64'd1 << GK) + 64'(GROUP_SIZE) - 64'd1) / 64'(GROUP_SIZE));

  logic [GSUM_W-1:0] acc_r;
  logic [GSUM_W-1:0] acc_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              v1_r;
  logic              v2_r;
  logic [GSUM_W-1:0] s1_sum_r;
  logic              s1_clr_r;
  oms_pkg::blk_t     blk_r;
  logic              s1_rdy;
  logic              s2_rdy;
  logic              accept;
  logic              is_clr;
  logic              done;
  logic [GP_W-1:0]   gprod;

  assign s2_rdy   = !v2_r || blk_ready;
  assign s1_rdy   = !v1_r || s2_rdy;
  assign in_ready = s1_rdy;
  assign accept   = in_valid && in_ready;
  assign is_clr   = (in_data.op == oms_pkg::OP_CLEAR);
  assign acc_nxt  = acc_r + GSUM_W'(in_data.sample);
  assign done     = !is_clr && (cnt_r == CNT_W'(GROUP_SIZE - 1));
  assign gprod    = GP_W'(s1_sum_r) * GP_W'(GDIV_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      if (accept) begin
        if (is_clr || done) begin
          acc_r <= '0;
          cnt_r <= '0;
        end else begin
          acc_r <= acc_nxt;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (s1_rdy) begin
        v1_r <= accept && (is_clr || done);
      end
      if (s2_rdy) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sum_r <= acc_nxt;
      s1_clr_r <= is_clr;
    end
    if (s2_rdy && v1_r) begin
      blk_r.clr <= s1_clr_r;
      blk_r.avg <= gprod[GK +: oms_pkg::SAMPLE_BITS];
    end
  end

  assign blk_valid = v2_r;
  assign blk_data  = blk_r;

endmodule

`default_nettype wire

[rtl/core/oms_ring.sv]
// Block average ring with running sum (read stage, update stage).
// Depends on oms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oms_ring #(
  parameter int WINDOW_DEPTH = 32,
  parameter int RSUM_W = $clog2(WINDOW_DEPTH * ((1 << oms_pkg::SAMPLE_BITS) - 1) + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              blk_valid,
  output logic                   blk_ready,
  input  wire oms_pkg::blk_t     blk_data,
  output logic                   sum_valid,
  input  wire logic              sum_ready,
  output logic [RSUM_W-1:0]      sum_data
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int SB    = oms_pkg::SAMPLE_BITS;

  logic [SB-1:0]           ring_mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] vld_r;
  logic [IDX_W-1:0]        ptr_r;
  logic [IDX_W-1:0]        ptr_nxt;
  logic [RSUM_W-1:0]       ring_sum_r;
  logic [RSUM_W-1:0]       rsum_nxt;
  logic                    v3_r;
  logic                    v4_r;
  logic [SB-1:0]           avg3_r;
  logic                    clr3_r;
  logic [IDX_W-1:0]        idx3_r;
  logic [SB-1:0]           rd_r;
  logic                    rdv_r;
  logic [SB-1:0]           old_val;
  logic [RSUM_W-1:0]       sum4_r;
  logic                    s3_rdy;
  logic                    s4_rdy;
  logic                    take3;
  logic                    take4;

  assign s4_rdy    = !v4_r || sum_ready;
  assign s3_rdy    = !v3_r || s4_rdy;
  assign blk_ready = s3_rdy;
  assign take3     = blk_valid && s3_rdy;
  assign take4     = v3_r && s4_rdy;
  assign ptr_nxt   = (ptr_r == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
  assign old_val   = rdv_r ? rd_r : '0;
  assign rsum_nxt  = ring_sum_r - RSUM_W'(old_val) + RSUM_W'(avg3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      vld_r      <= '0;
      ring_sum_r <= '0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
    end else begin
      if (take4) begin
        if (clr3_r) begin
          ring_sum_r <= '0;
        end else begin
          ring_sum_r     <= rsum_nxt;
          if (!(take3 && blk_data.clr)) begin
            vld_r[idx3_r] <= 1'b1;
          end
        end
      end
      if (take3) begin
        if (blk_data.clr) begin
          ptr_r <= '0;
          vld_r <= '0;
        end else begin
          ptr_r <= ptr_nxt;
        end
      end
      if (s3_rdy) begin
        v3_r <= blk_valid;
      end
      if (s4_rdy) begin
        v4_r <= v3_r && !clr3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take4 && !clr3_r) begin
      ring_mem[idx3_r] <= avg3_r;
    end
    if (take3) begin
      rd_r <= ring_mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (take3) begin
      avg3_r <= blk_data.avg;
      clr3_r <= blk_data.clr;
      idx3_r <= ptr_r;
      rdv_r  <= vld_r[ptr_r];
    end
    if (take4) begin
      sum4_r <= rsum_nxt;
    end
  end

  assign sum_valid = v4_r;
  assign sum_data  = sum4_r;

endmodule

`default_nettype wire

[rtl/core/oms_scale.sv]
// Window divider, coefficient multiply and saturation, with the result register.
// Depends on oms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oms_scale #(
  parameter int WINDOW_DEPTH   = 32,
  parameter int COEF_FRAC_BITS = 16,
  parameter int RSUM_W = $clog2(WINDOW_DEPTH * ((1 << oms_pkg::SAMPLE_BITS) - 1) + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           sum_valid,
  output logic                                sum_ready,
  input  wire logic [RSUM_W-1:0]              sum_data,
  input  wire logic [oms_pkg::COEF_BITS-1:0]  coef,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output oms_pkg::out_res_t                   out_data
);

  localparam int SB     = oms_pkg::SAMPLE_BITS;
  localparam int VB     = oms_pkg::VOLT_BITS;
  localparam int WK     = RSUM_W + $clog2(WINDOW_DEPTH);
  localparam int WM_W   = RSUM_W + 1;
  localparam int WP_W   = RSUM_W + WM_W;
  localparam int PROD_W = oms_pkg::COEF_BITS + SB;
  localparam logic [WM_W-1:0] WDIV_M =
    WM_W'(((64'd1 << WK) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

  logic [WP_W-1:0]   wprod;
  logic [PROD_W-1:0] prod;
  logic              sat;
  logic [VB-1:0]     volt;
  logic              v5_r;
  logic [SB-1:0]     filt5_r;
  logic              ov_r;
  oms_pkg::out_res_t out_r;
  logic              out_rdy;
  logic              s5_rdy;

  assign out_rdy   = !ov_r || out_ready;
  assign s5_rdy    = !v5_r || out_rdy;
  assign sum_ready = s5_rdy;
  assign wprod     = WP_W'(sum_data) * WP_W'(WDIV_M);
  assign prod      = PROD_W'(coef) * PROD_W'(filt5_r);
  assign sat       = |prod[PROD_W-1:COEF_FRAC_BITS+VB];
  assign volt      = sat ? {VB{1'b1}} : prod[COEF_FRAC_BITS +: VB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (s5_rdy) begin
        v5_r <= sum_valid;
      end
      if (out_rdy) begin
        ov_r <= v5_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s5_rdy && sum_valid) begin
      filt5_r <= wprod[WK +: SB];
    end
    if (out_rdy && v5_r) begin
      out_r.filtered_average <= filt5_r;
      out_r.voltage          <= volt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[bench/oversampled_moving_average_scaler_top_tb.sv]
// Self-checking bench for oversampled_moving_average_scaler_top: decimation,
// the 32-entry moving average, clear requests and the Q16.16 voltage scaler.
// Depends on oms_pkg and the RTL top; predicts every reading in-bench.
`timescale 1ns / 1ps

module oversampled_moving_average_scaler_top_tb;

  localparam int SAMPLE_BITS    = oms_pkg::SAMPLE_BITS;
  localparam int COEF_BITS      = oms_pkg::COEF_BITS;
  localparam int GROUP_LEN      = 16;
  localparam int WINDOW_LEN     = 32;
  localparam int FRAC_BITS      = 16;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 1000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  oms_pkg::in_req_t     in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  oms_pkg::out_res_t    out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [COEF_BITS-1:0] cfg_wr_data = '0;

  // bench copy of the block state
  logic [COEF_BITS-1:0]   coef_q;
  logic [15:0]            grp_sum;
  logic [4:0]             grp_len;
  logic [SAMPLE_BITS-1:0] blk_ring [WINDOW_LEN];
  logic [4:0]             ring_wr_ptr;
  logic [16:0]            window_sum;

  oms_pkg::out_res_t pending_readings[$];

  bit src_idle_en = 1'b0;
  bit snk_idle_en = 1'b0;
  int req_count = 0;
  int clear_count = 0;
  int reading_count = 0;
  int coef_settings = 0;
  int err_count = 0;
  int idle_cycles = 0;

  oversampled_moving_average_scaler_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_filter();
    grp_sum     = '0;
    grp_len     = '0;
    ring_wr_ptr = '0;
    window_sum  = '0;
    for (int k = 0; k < WINDOW_LEN; k++) blk_ring[k] = '0;
  endfunction

  function automatic void advance_filter(input oms_pkg::in_req_t req);
    logic [SAMPLE_BITS-1:0] blk_avg;
    logic [SAMPLE_BITS-1:0] filt;
    logic [63:0]            prod;
    oms_pkg::out_res_t      reading;
    if (req.op == oms_pkg::OP_CLEAR) begin
      clear_filter();
      return;
    end
    grp_sum = grp_sum + 16'(req.sample);
    grp_len = grp_len + 5'd1;
    if (grp_len < GROUP_LEN) return;
    blk_avg = SAMPLE_BITS'(grp_sum >> 4);
    grp_sum = '0;
    grp_len = '0;
    window_sum = window_sum - 17'(blk_ring[ring_wr_ptr]) + 17'(blk_avg);
    blk_ring[ring_wr_ptr] = blk_avg;
    ring_wr_ptr = ring_wr_ptr + 5'd1;
    filt = SAMPLE_BITS'(window_sum >> 5);
    prod = (64'(coef_q) * 64'(filt)) >> FRAC_BITS;
    reading.filtered_average = filt;
    reading.voltage = (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
    pending_readings.push_back(reading);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return '1;
      1: return '0;
      2: return SAMPLE_BITS'($urandom_range(3800, 4095));
      default: return SAMPLE_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  // call at a rising edge; returns at the edge that accepts the request
  task automatic send_req(input oms_pkg::in_req_t req);
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    advance_filter(req);
    req_count++;
    if (req.op == oms_pkg::OP_CLEAR) clear_count++;
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
    oms_pkg::in_req_t req;
    req.op     = oms_pkg::OP_SAMPLE;
    req.sample = value;
    send_req(req);
  endtask

  task automatic wait_for_readings();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  task automatic write_coef(input logic [COEF_BITS-1:0] value);
    wait_for_readings();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    coef_q = value;
    coef_settings++;
  endtask

  task automatic test_partial_group_and_clear();
    oms_pkg::in_req_t req;
    for (int i = 0; i < 7; i++) send_sample((i % 2) ? '1 : '0);
    req.op     = oms_pkg::OP_CLEAR;
    req.sample = '1;
    send_req(req);
  endtask

  task automatic test_extreme_group();
    send_sample('0);
    for (int i = 1; i < GROUP_LEN; i++) send_sample('1);
  endtask

  task automatic test_voltage_saturation();
    write_coef('1);
    for (int i = 0; i < GROUP_LEN; i++) send_sample('1);
  endtask

  task automatic test_random_phase(input int n_req, input logic [COEF_BITS-1:0] coef_val,
                                   input bit src_idle, input bit snk_idle,
                                   input int pause_at);
    oms_pkg::in_req_t req;
    write_coef(coef_val);
    src_idle_en = src_idle;
    snk_idle_en = snk_idle;
    for (int i = 0; i < n_req; i++) begin
      if (i == pause_at) wait_for_readings();
      req.op     = ($urandom_range(0, 299) == 0) ? oms_pkg::OP_CLEAR : oms_pkg::OP_SAMPLE;
      req.sample = pick_sample();
      send_req(req);
    end
  endtask

  // random stalls on the result side
  initial begin
    forever begin
      @(posedge clk);
      if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    oms_pkg::out_res_t want;
    if (rst_n && out_valid && out_ready) begin
      reading_count++;
      if (pending_readings.size() == 0) begin
        $error("unexpected reading: filtered_average %0d voltage %0d",
               out_data.filtered_average, out_data.voltage);
        err_count++;
      end else begin
        want = pending_readings.pop_front();
        if (out_data.filtered_average !== want.filtered_average) begin
          $error("filtered_average: expected %0d, got %0d",
                 want.filtered_average, out_data.filtered_average);
          err_count++;
        end
        if (out_data.voltage !== want.voltage) begin
          $error("voltage: expected %0d, got %0d", want.voltage, out_data.voltage);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    coef_q = oms_pkg::COEF_RESET;
    clear_filter();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_partial_group_and_clear();
    test_extreme_group();
    test_voltage_saturation();
    test_random_phase(250, oms_pkg::COEF_RESET, 1'b1, 1'b1, 120);
    test_random_phase(200, '0, 1'b1, 1'b0, -1);
    test_random_phase(250, '1, 1'b0, 1'b1, -1);
    test_random_phase(200, 32'd1, 1'b1, 1'b1, -1);
    test_random_phase(300, $urandom, 1'b1, 1'b1, -1);
    test_random_phase(300, 32'($urandom_range(0, 32'h3FFFF)), 1'b0, 1'b0, -1);

    wait_for_readings();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (pending_readings.size() != 0) begin
      $error("%0d readings never arrived", pending_readings.size());
      err_count++;
    end

    $display("Sent %0d requests (%0d clears) under %0d coefficient settings,",
             req_count, clear_count, coef_settings);
    $display("checked %0d readings with random stalls on both sides.", reading_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/oms_pkg.sv
rtl/core/oms_decim.sv
rtl/core/oms_ring.sv
rtl/core/oms_scale.sv
rtl/core/oversampled_moving_average_scaler_top.sv
bench/oversampled_moving_average_scaler_top_tb.sv
